/* src/iir4_pkg.sv */
// Shared types and constants for the fourth-order IIR filter unit.
// No dependencies; imported by every module of the block.
package iir4_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int COEF_FRAC  = 27;
  localparam int RES_W      = 27;
  localparam int GAIN_W     = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int HIST_DEPTH = 4;
  localparam int CLIP_LEVEL = 4194304;

  // x0 + 4x1 + 6x2 + 4x3 + x4 on clipped samples reaches 2^26
  localparam int TAPS_W = 28;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int MUL_A_W = COEF_W + 1;
  localparam int MUL_B_W = TAPS_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int TERM_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGHPASS = 3'd0,
    REG_FWD_GAIN = 3'd1,
    REG_FB_ONE   = 3'd2,
    REG_FB_TWO   = 3'd3,
    REG_FB_THREE = 3'd4,
    REG_FB_FOUR  = 3'd5,
    REG_RESON    = 3'd6,
    REG_OUT_GAIN = 3'd7
  } cfg_reg_e;

  // operand pair selected for the shared multiplier
  typedef enum logic [TERM_W-1:0] {
    TERM_FWD  = 3'd0,
    TERM_FB1  = 3'd1,
    TERM_FB2  = 3'd2,
    TERM_FB3  = 3'd3,
    TERM_FB4  = 3'd4,
    TERM_RES  = 3'd5,
    TERM_GAIN = 3'd6
  } term_e;

  typedef struct packed {
    logic  load_in;   // capture and clip new sample, clear accumulator
    logic  prep;      // form tap sum and resonance difference
    logic  mul_en;    // register one product
    term_e term;
    logic  acc_add;   // add registered product into accumulator
    logic  update;    // truncate, clip, shift histories
    logic  out_load;  // scale result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

/* src/iir4_ctrl.sv */
// Sequencer for the IIR filter: walks one sample through the datapath.
// Depends on iir4_pkg.
module iir4_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  iir4_pkg::dp_status_t status_i,
  output iir4_pkg::dp_cmd_t    cmd_o
);
  import iir4_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_MAC   = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_SCALE = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [TERM_W-1:0]   cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = TERM_W'(TERM_FWD);
        state_d    = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.term    = term_e'(cnt_q);
        cmd_o.acc_add = (cnt_q != TERM_W'(TERM_FWD));
        if (cnt_q == TERM_W'(TERM_RES)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + TERM_W'(1);
        end
      end
      ST_DRAIN: begin
        cmd_o.acc_add = 1'b1;
        state_d       = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.update = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.term   = TERM_GAIN;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* src/iir4_datapath.sv */
// Datapath of the IIR filter: config registers, histories, shared multiplier,
// accumulator and output register. Depends on iir4_pkg.
module iir4_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [iir4_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [iir4_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic [iir4_pkg::SAMPLE_W-1:0]         sample_i,
  output logic [iir4_pkg::SAMPLE_W-1:0]         sample_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  input  iir4_pkg::dp_cmd_t                     cmd_i,
  output iir4_pkg::dp_status_t                  status_o
);
  import iir4_pkg::*;

  localparam int SH_W = PROD_W - COEF_FRAC;
  localparam logic signed [SH_W-1:0] Y_HI = SH_W'(CLIP_LEVEL);
  localparam logic signed [SH_W-1:0] Y_LO = -Y_HI;
  localparam logic signed [SH_W-1:0] S_HI = SH_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] S_LO = -S_HI - SH_W'(1);
  localparam logic signed [SAMPLE_W-1:0] X_HI = SAMPLE_W'(CLIP_LEVEL);

  // configuration
  logic                     hp_q;
  logic signed [COEF_W-1:0] fwd_q;
  logic signed [COEF_W-1:0] fb_q [HIST_DEPTH];
  logic [RES_W-1:0]         res_q;
  logic [GAIN_W-1:0]        gain_q;

  // state and working registers
  logic signed [SAMPLE_W-1:0] in_hist_q  [HIST_DEPTH];
  logic signed [SAMPLE_W-1:0] out_hist_q [HIST_DEPTH];
  logic signed [SAMPLE_W-1:0] x0_q, x0_d;
  logic signed [TAPS_W-1:0]   taps_q, taps_d, tap_odd, tap_even;
  logic signed [DIFF_W-1:0]   diff_q, diff_d;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [PROD_W-1:0]   acc_q, acc_d;
  logic signed [SH_W-1:0]     acc_sh, prod_sh;
  logic signed [SAMPLE_W-1:0] y_new, scaled;
  logic [SAMPLE_W-1:0]        out_data_q;
  logic                       out_valid_q;

  function automatic logic signed [TAPS_W-1:0] tx(input logic signed [SAMPLE_W-1:0] v);
    tx = {{(TAPS_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  function automatic logic signed [MUL_A_W-1:0] ca(input logic signed [COEF_W-1:0] v);
    ca = {{(MUL_A_W - COEF_W){v[COEF_W-1]}}, v};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q   <= 1'b0;
      fwd_q  <= '0;
      res_q  <= '0;
      gain_q <= GAIN_W'(1) << COEF_FRAC;
      for (int i = 0; i < HIST_DEPTH; i++) fb_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HIGHPASS: hp_q      <= cfg_data_i[0];
        REG_FWD_GAIN: fwd_q     <= cfg_data_i[COEF_W-1:0];
        REG_FB_ONE:   fb_q[0]   <= cfg_data_i[COEF_W-1:0];
        REG_FB_TWO:   fb_q[1]   <= cfg_data_i[COEF_W-1:0];
        REG_FB_THREE: fb_q[2]   <= cfg_data_i[COEF_W-1:0];
        REG_FB_FOUR:  fb_q[3]   <= cfg_data_i[COEF_W-1:0];
        REG_RESON:    res_q     <= cfg_data_i[RES_W-1:0];
        REG_OUT_GAIN: gain_q    <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input clip
  always_comb begin
    x0_d = sample_i;
    if ($signed(sample_i) > X_HI) begin
      x0_d = X_HI;
    end else if ($signed(sample_i) < -X_HI) begin
      x0_d = -X_HI;
    end
  end

  // binomial tap sum, odd taps negated in highpass mode
  always_comb begin
    tap_odd  = (tx(in_hist_q[0]) <<< 2) + (tx(in_hist_q[2]) <<< 2);
    tap_even = tx(x0_q) + (tx(in_hist_q[1]) <<< 2) + (tx(in_hist_q[1]) <<< 1)
             + tx(in_hist_q[3]);
    taps_d   = hp_q ? (tap_even - tap_odd) : (tap_even + tap_odd);
    diff_d   = DIFF_W'(in_hist_q[0]) - DIFF_W'(in_hist_q[2]);
  end

  // shared multiplier operands; feedback coefficients enter negated
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.term)
      TERM_FWD: begin
        mul_a = ca(fwd_q);
        mul_b = taps_q;
      end
      TERM_FB1: begin
        mul_a = -ca(fb_q[0]);
        mul_b = MUL_B_W'(out_hist_q[0]);
      end
      TERM_FB2: begin
        mul_a = -ca(fb_q[1]);
        mul_b = MUL_B_W'(out_hist_q[1]);
      end
      TERM_FB3: begin
        mul_a = -ca(fb_q[2]);
        mul_b = MUL_B_W'(out_hist_q[2]);
      end
      TERM_FB4: begin
        mul_a = -ca(fb_q[3]);
        mul_b = MUL_B_W'(out_hist_q[3]);
      end
      TERM_RES: begin
        mul_a = $signed({{(MUL_A_W - RES_W){1'b0}}, res_q});
        mul_b = MUL_B_W'(diff_q);
      end
      TERM_GAIN: begin
        mul_a = $signed({{(MUL_A_W - GAIN_W){1'b0}}, gain_q});
        mul_b = MUL_B_W'(out_hist_q[0]);
      end
      default: ;
    endcase
    prod_d = mul_a * mul_b;
  end

  // truncation toward minus infinity, then clip
  always_comb begin
    acc_d   = cmd_i.load_in ? '0 : (acc_q + prod_q);
    acc_sh  = SH_W'(acc_q >>> COEF_FRAC);
    prod_sh = SH_W'(prod_q >>> COEF_FRAC);
    if (acc_sh > Y_HI) begin
      y_new = SAMPLE_W'(Y_HI);
    end else if (acc_sh < Y_LO) begin
      y_new = SAMPLE_W'(Y_LO);
    end else begin
      y_new = SAMPLE_W'(acc_sh);
    end
    if (prod_sh > S_HI) begin
      scaled = SAMPLE_W'(S_HI);
    end else if (prod_sh < S_LO) begin
      scaled = SAMPLE_W'(S_LO);
    end else begin
      scaled = SAMPLE_W'(prod_sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) x0_q <= x0_d;
    if (cmd_i.prep) begin
      taps_q <= taps_d;
      diff_q <= diff_d;
    end
    if (cmd_i.mul_en) prod_q <= prod_d;
    if (cmd_i.load_in || cmd_i.acc_add) acc_q <= acc_d;
    if (cmd_i.out_load) out_data_q <= scaled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        in_hist_q[i]  <= '0;
        out_hist_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        in_hist_q[i]  <= in_hist_q[i-1];
        out_hist_q[i] <= out_hist_q[i-1];
      end
      in_hist_q[0]  <= x0_q;
      out_hist_q[0] <= y_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_o          = out_data_q;

endmodule

/* src/fourth_order_iir_filter_unit.sv */
// Top level of the fourth-order IIR filter unit: sequencer plus datapath.
// Depends on iir4_pkg, iir4_ctrl, iir4_datapath.
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata[23:0] sample_in
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata[23:0] sample_out
//  cfg       in   cfg_we_i (no wait)             cfg_idx_i register, cfg_data_i value
//
// After its input transfer, a sample goes through capture and clip, tap sum, six
// products through the one 33x28 multiplier (one per cycle, each accumulated in
// the following cycle), truncate/clip/history shift and the output-gain product.
// One sample is in flight at a time; the shared multiplier sets this.
// The input reopens once the result sits in the output register; the next result
// waits until that register frees. Reset clears histories and config (gain 1.0).
module fourth_order_iir_filter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [iir4_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [iir4_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [iir4_pkg::SAMPLE_W-1:0]   s_axis_tdata,   // [23:0] sample_in
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [iir4_pkg::SAMPLE_W-1:0]   m_axis_tdata    // [23:0] sample_out
);
  import iir4_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  iir4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  iir4_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata),
    .sample_o    (m_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // one sample in flight: no new transfer right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a sample is in flight");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  // history shift and multiplier issue never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.update && cmd.mul_en))
    else $error("history update during multiply");

endmodule

/* bench/iir4_checker.sv */
// Checker for the fourth-order IIR filter unit: watches config writes and both streams,
// keeps its own filter state and compares every output transfer. Depends on iir4_pkg.
module iir4_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [iir4_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [iir4_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [iir4_pkg::SAMPLE_W-1:0]   s_axis_tdata,   // [23:0] sample_in
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [iir4_pkg::SAMPLE_W-1:0]   m_axis_tdata,   // [23:0] sample_out
  output int                              mismatch_cnt_o,
  output int                              samples_in_flight_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import iir4_pkg::*;

  localparam longint CLIP = CLIP_LEVEL;
  localparam longint SMAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  // register mirror
  logic                     highpass;
  logic signed [COEF_W-1:0] fwd_gain;
  logic signed [COEF_W-1:0] feedback [HIST_DEPTH];
  logic [RES_W-1:0]         resonance;
  logic [GAIN_W-1:0]        out_gain;

  // past clipped inputs and past stored outputs, index 0 is the newest
  longint x_hist [HIST_DEPTH];
  longint y_hist [HIST_DEPTH];

  logic [SAMPLE_W-1:0] expected_samples [$];
  int mismatch_cnt;
  int in_flight;

  assign mismatch_cnt_o      = mismatch_cnt;
  assign samples_in_flight_o = in_flight;

  function automatic longint clip_to(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one step of the recursion; advances the history
  function automatic logic [SAMPLE_W-1:0] predict_filter_output(
    input logic [SAMPLE_W-1:0] sample
  );
    longint x0, taps, acc, y, scaled, coef;
    x0 = clip_to(longint'($signed(sample)), -CLIP, CLIP);
    taps = 4 * x_hist[0] + 4 * x_hist[2];
    if (highpass) taps = -taps;
    taps += x0 + 6 * x_hist[1] + x_hist[3];
    coef = fwd_gain;
    acc = coef * taps;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      coef = feedback[i];
      acc -= coef * y_hist[i];
    end
    coef = resonance;
    acc += coef * (x_hist[0] - x_hist[2]);
    // arithmetic shift of a signed value truncates toward minus infinity
    y = clip_to(acc >>> COEF_FRAC, -CLIP, CLIP);
    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
      x_hist[i] = x_hist[i-1];
      y_hist[i] = y_hist[i-1];
    end
    x_hist[0] = x0;
    y_hist[0] = y;
    coef = out_gain;
    scaled = clip_to((y * coef) >>> COEF_FRAC, SMIN, SMAX);
    return scaled[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      highpass  = 1'b0;
      fwd_gain  = '0;
      resonance = '0;
      out_gain  = '0;
      out_gain[COEF_FRAC] = 1'b1;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        feedback[i] = '0;
        x_hist[i]   = 0;
        y_hist[i]   = 0;
      end
      expected_samples.delete();
      mismatch_cnt = 0;
      in_flight <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_HIGHPASS: highpass    = cfg_data_i[0];
          REG_FWD_GAIN: fwd_gain    = cfg_data_i[COEF_W-1:0];
          REG_FB_ONE:   feedback[0] = cfg_data_i[COEF_W-1:0];
          REG_FB_TWO:   feedback[1] = cfg_data_i[COEF_W-1:0];
          REG_FB_THREE: feedback[2] = cfg_data_i[COEF_W-1:0];
          REG_FB_FOUR:  feedback[3] = cfg_data_i[COEF_W-1:0];
          REG_RESON:    resonance   = cfg_data_i[RES_W-1:0];
          REG_OUT_GAIN: out_gain    = cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_samples.push_back(predict_filter_output(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample_out transfer, expected none, got %h",
                   $time, m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: sample_out mismatch, expected %h, got %h",
                     $time, want, m_axis_tdata);
            mismatch_cnt++;
          end
        end
      end
      in_flight <= expected_samples.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for fourth_order_iir_filter_unit: clock, reset, config phases and
// stream stimulus with random idling. Depends on iir4_pkg, iir4_checker and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import iir4_pkg::*;

  // generous bound: ~1200 samples plus the long stalls
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 130;   // per config phase
  localparam int NUM_SETTINGS = 9;
  localparam int DRAIN_CYCLES = 16;    // longer than the sample latency
  localparam int LONG_HOLD    = 250;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata;   // [23:0] sample_in
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [SAMPLE_W-1:0]   m_axis_tdata;   // [23:0] sample_out

  int mismatch_cnt;
  int samples_in_flight;
  int cycle_cnt;
  bit no_idle;       // both sides run back to back while set
  int last_sample;   // anchor for the random walk

  // corners of the input: full-scale, clip level and one beyond, single-LSB,
  // alternating bit patterns, then a unit step and its release
  logic [SAMPLE_W-1:0] corner_samples [22] = '{
    24'h000000, 24'h7FFFFF, 24'h800000, 24'h400000, 24'hC00000, 24'h400001,
    24'hBFFFFF, 24'h3FFFFF, 24'h000001, 24'hFFFFFF, 24'hAAAAAA, 24'h555555,
    24'h100000, 24'h100000, 24'h100000, 24'h100000, 24'h100000, 24'h100000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000
  };

  fourth_order_iir_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  iir4_checker filter_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .s_axis_tvalid       (s_axis_tvalid),
    .s_axis_tready       (s_axis_tready),
    .s_axis_tdata        (s_axis_tdata),
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tready       (m_axis_tready),
    .m_axis_tdata        (m_axis_tdata),
    .mismatch_cnt_o      (mismatch_cnt),
    .samples_in_flight_o (samples_in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Mixed sample source: mostly in-range values and a slow random walk (keeps
  // the recursion in a settled regime), with full-range noise, clip corners
  // and tiny values mixed in.
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    int v;
    int extreme_vals [8];
    extreme_vals = '{8388607, -8388608, CLIP_LEVEL, -CLIP_LEVEL,
                     CLIP_LEVEL + 1, -CLIP_LEVEL - 1, 0, -1};
    case ($urandom_range(0, 9))
      0:       v = $urandom;
      1:       v = extreme_vals[$urandom_range(0, 7)];
      2, 3, 4: begin
        v = last_sample + int'($urandom_range(0, 131072)) - 65536;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
      end
      5:       v = int'($urandom_range(0, 8192)) - 4096;
      default: v = int'($urandom_range(0, 2 * CLIP_LEVEL)) - CLIP_LEVEL;
    endcase
    last_sample = $signed(v[SAMPLE_W-1:0]);
    return v[SAMPLE_W-1:0];
  endfunction

  // coefficient anywhere in Q4.27, or within +/-0.5 / +/-0.0625 for sane poles
  function automatic logic [CFG_DATA_W-1:0] draw_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 2))
      0:       return r;
      1:       return {{5{r[26]}}, r[26:0]};
      default: return {{8{r[23]}}, r[23:0]};
    endcase
  endfunction

  // One input transfer. tvalid stays high on return so a back-to-back next
  // sample does not toggle it within one step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted sample has been taken.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (samples_in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  // Config phases: a stable lowpass, a highpass with resonance, both full-scale
  // extremes (sum saturation, gain above one, zero gain), a resonant lowpass,
  // then random sets. Narrow registers get junk in the unused upper bits.
  task automatic apply_setting(input int k);
    logic [CFG_DATA_W-1:0] hp, fwd, res, gain;
    logic [CFG_DATA_W-1:0] fb [HIST_DEPTH];
    // (1 - 0.5/z)^4 poles, unity DC gain for the lowpass taps
    fwd = 32'd524288;
    fb  = '{32'hF000_0000, 32'h0C00_0000, 32'hFC00_0000, 32'h0080_0000};
    hp   = 32'h0;
    res  = 32'h0;
    gain = 32'h0800_0000;
    case (k)
      0: ;
      1: begin
        hp   = 32'hFFFF_FFFF;
        res  = {5'h1F, 27'h200_0000};
        gain = {4'hA, 28'h400_0000};
      end
      2: begin
        fwd  = 32'h7FFF_FFFF;
        fb   = '{default: 32'h8000_0000};
        res  = 32'h07FF_FFFF;
        gain = 32'hFFFF_FFFF;
      end
      3: begin
        hp   = 32'h1;
        fwd  = 32'h8000_0000;
        fb   = '{default: 32'h7FFF_FFFF};
        gain = 32'h0;
      end
      4: begin
        hp   = 32'hFFFF_FFFE;
        res  = 32'h0100_0000;
        gain = 32'h0E00_0000;
      end
      default: begin
        hp  = $urandom;
        fwd = draw_coef();
        foreach (fb[i]) fb[i] = draw_coef();
        res  = $urandom;
        gain = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0800_0000);
      end
    endcase
    write_reg(REG_HIGHPASS, hp);
    write_reg(REG_FWD_GAIN, fwd);
    write_reg(REG_FB_ONE,   fb[0]);
    write_reg(REG_FB_TWO,   fb[1]);
    write_reg(REG_FB_THREE, fb[2]);
    write_reg(REG_FB_FOUR,  fb[3]);
    write_reg(REG_RESON,    res);
    write_reg(REG_OUT_GAIN, gain);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Output side: a random idle gap before each transfer, except twice a long hold-off
  // that lets the block fill and stall its input while samples keep coming.
  initial begin
    int gap;
    int results_taken;
    results_taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (results_taken == 300 || results_taken == 800) gap = LONG_HOLD;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      results_taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_HIGHPASS;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    no_idle       = 1'b0;
    last_sample   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: zero coefficients, but the input history still fills
    repeat (6) send_sample(draw_sample());
    wait_idle();

    for (int k = 0; k < NUM_SETTINGS; k++) begin
      no_idle = (k % 3 == 2);
      apply_setting(k);
      if (k == 0)
        foreach (corner_samples[i]) send_sample(corner_samples[i]);
      repeat (RANDOM_ITEMS) send_sample(draw_sample());
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
